[rtl/bdmn_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdmn_pkg
// Shared types and constants for the button debounce menu navigator.
// ----------------------------------------------------------------------------
package bdmn_pkg;

   // Fixed geometry of the button bank and the result fields
   localparam int BUTTON_COUNT = 6;
   localparam int LIMIT_W      = 4;
   localparam int PAGE_W       = 3;
   localparam int STATES_W     = 2 * BUTTON_COUNT;

   // Button positions on the pin bus
   localparam int KEY_UP     = 0;
   localparam int KEY_DOWN   = 1;
   localparam int KEY_RIGHT  = 2;
   localparam int KEY_LEFT   = 3;
   localparam int KEY_SELECT = 4;
   localparam int KEY_RETURN = 5;

   // Debounced button level codes
   typedef logic [1:0] level_type;
   localparam level_type LVL_UP   = 2'd0;
   localparam level_type LVL_DOWN = 2'd1;
   localparam level_type LVL_HELD = 2'd2;

   // Screen mode codes
   localparam logic MODE_MONITOR = 1'b0;
   localparam logic MODE_MENU    = 1'b1;

   // Navigator result for one beat
   typedef struct packed {
      logic              in_menu;
      logic [PAGE_W-1:0] menu_page;
      logic              redraw;
   } nav_status_type;

endpackage
`default_nettype wire

[rtl/bdmn_channels.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdmn channel interfaces
// Valid/ready channels for pin samples, results and the limit register.
// ----------------------------------------------------------------------------
interface bdmn_req_if;
   logic       valid;
   logic       ready;
   logic [5:0] raw_pins;

   modport source (output valid, output raw_pins, input ready);
   modport sink   (input valid, input raw_pins, output ready);
endinterface

interface bdmn_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] button_states;
   logic        in_menu;
   logic [2:0]  menu_page;
   logic        redraw;

   modport source (output valid, output button_states, output in_menu,
                   output menu_page, output redraw, input ready);
   modport sink   (input valid, input button_states, input in_menu,
                   input menu_page, input redraw, output ready);
endinterface

interface bdmn_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/bdmn_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdmn_lane
// One button: up/down qualify counter and up/down/held level tracker.
// ----------------------------------------------------------------------------
module bdmn_lane #(
   parameter int COUNT_WIDTH = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic                   pin,
   input  wire logic [COUNT_WIDTH-1:0] limit,
   output bdmn_pkg::level_type         level_nx
);
   import bdmn_pkg::*;

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   level_type              level_ff, level_in;
   logic                   pressed;

   // Qualify the pin level and advance the button level
   always_comb begin
      pressed  = ~pin;
      count_in = count_ff;
      level_in = level_ff;
      if (pressed) begin
         if (count_ff < limit) begin
            count_in = count_ff + 1'b1;
         end else begin
            level_in = (level_ff == LVL_UP) ? LVL_DOWN : LVL_HELD;
         end
      end else begin
         if (count_ff != '0) begin
            count_in = count_ff - 1'b1;
         end else begin
            level_in = LVL_UP;
         end
      end
   end

   assign level_nx = level_in;

   // Hold state between beats
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         level_ff <= LVL_UP;
      end else if (step) begin
         count_ff <= count_in;
         level_ff <= level_in;
      end
   end

endmodule
`default_nettype wire

[rtl/bdmn_nav.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdmn_nav
// Merge stage: click latches, screen mode and menu page.
// ----------------------------------------------------------------------------
module bdmn_nav #(
   parameter int PAGE_COUNT = 6
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  bdmn_pkg::level_type       level_nx [bdmn_pkg::BUTTON_COUNT],
   output bdmn_pkg::nav_status_type  status
);
   import bdmn_pkg::*;

   localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGE_COUNT - 1);

   logic [BUTTON_COUNT-1:0] latch_ff, latch_in;
   logic                    mode_ff, mode_in;
   logic [PAGE_W-1:0]       page_ff, page_in;
   logic                    redraw;
   logic                    click_up, click_right, click_left, click_return;

   // Resolve clicks for the buttons the current mode watches
   always_comb begin
      latch_in     = latch_ff;
      mode_in      = mode_ff;
      page_in      = page_ff;
      redraw       = 1'b0;
      click_up     = 1'b0;
      click_right  = 1'b0;
      click_left   = 1'b0;
      click_return = 1'b0;

      if (mode_ff == MODE_MONITOR) begin
         if (level_nx[KEY_UP] == LVL_DOWN) begin
            latch_in[KEY_UP] = 1'b1;
         end else if (level_nx[KEY_UP] == LVL_UP && latch_ff[KEY_UP]) begin
            latch_in[KEY_UP] = 1'b0;
            click_up         = 1'b1;
         end
      end else begin
         if (level_nx[KEY_RIGHT] == LVL_DOWN) begin
            latch_in[KEY_RIGHT] = 1'b1;
         end else if (level_nx[KEY_RIGHT] == LVL_UP && latch_ff[KEY_RIGHT]) begin
            latch_in[KEY_RIGHT] = 1'b0;
            click_right         = 1'b1;
         end
         if (level_nx[KEY_LEFT] == LVL_DOWN) begin
            latch_in[KEY_LEFT] = 1'b1;
         end else if (level_nx[KEY_LEFT] == LVL_UP && latch_ff[KEY_LEFT]) begin
            latch_in[KEY_LEFT] = 1'b0;
            click_left         = 1'b1;
         end
         if (level_nx[KEY_RETURN] == LVL_DOWN) begin
            latch_in[KEY_RETURN] = 1'b1;
         end else if (level_nx[KEY_RETURN] == LVL_UP && latch_ff[KEY_RETURN]) begin
            latch_in[KEY_RETURN] = 1'b0;
            click_return         = 1'b1;
         end
      end

      // Apply clicks in order: up, right, left, return
      if (click_up) begin
         mode_in = MODE_MENU;
         redraw  = 1'b1;
      end
      if (click_right) begin
         page_in = (page_in < PAGE_LAST) ? page_in + 1'b1 : '0;
         redraw  = 1'b1;
      end
      if (click_left) begin
         page_in = (page_in != '0) ? page_in - 1'b1 : PAGE_LAST;
         redraw  = 1'b1;
      end
      if (click_return) begin
         mode_in = MODE_MONITOR;
         page_in = '0;
         redraw  = 1'b1;
      end
   end

   assign status.in_menu   = mode_in;
   assign status.menu_page = page_in;
   assign status.redraw    = redraw;

   // Hold navigation state between beats
   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff <= '0;
         mode_ff  <= MODE_MONITOR;
         page_ff  <= '0;
      end else if (step) begin
         latch_ff <= latch_in;
         mode_ff  <= mode_in;
         page_ff  <= page_in;
      end
   end

endmodule
`default_nettype wire

[rtl/button_debounce_menu_navigator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_debounce_menu_navigator
// Six-button debouncer driving a monitor/menu screen navigator.
//
// Usage:
//   req_bus carries one beat per tick: six active-low pin samples.
//   rsp_bus returns one beat per request: button levels, screen mode,
//   menu page and a redraw pulse.
//   csr_bus writes the 4-bit debounce limit; it is always ready and
//   should be written only while no beat is in flight.
// Timing:
//   Six lanes debounce the buttons in parallel, the navigator merges
//   their levels, and the result lands in the output register, so a
//   response is valid in the cycle after its request is taken; one
//   beat is taken every cycle while the response side keeps up.
// Reset clears all levels to up, all counters, latches, the limit,
// selects the monitor screen and page 0.
// Stall: while a response waits unclaimed, req_bus.ready drops; a beat
// is taken in the same cycle that the waiting response is taken.
// ----------------------------------------------------------------------------
module button_debounce_menu_navigator #(
   parameter int PAGE_COUNT  = 6,
   parameter int COUNT_WIDTH = 4
) (
   input wire logic   clock,
   input wire logic   reset,
   bdmn_req_if.sink   req_bus,
   bdmn_rsp_if.source rsp_bus,
   bdmn_csr_if.sink   csr_bus
);
   import bdmn_pkg::*;

   localparam logic [8:0] COUNT_MAX = 9'((1 << COUNT_WIDTH) - 1);

   logic [LIMIT_W-1:0]     limit_ff;
   logic [COUNT_WIDTH-1:0] limit_sat;
   logic [8:0]             limit_ext;
   logic                   req_ready;
   logic                   step;
   level_type              level_nx [BUTTON_COUNT];
   nav_status_type         status;
   logic [STATES_W-1:0]    states;
   logic                   rsp_valid_ff;
   logic [STATES_W-1:0]    states_ff;
   nav_status_type         status_ff;

   // Configuration register
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_bus.valid) begin
         limit_ff <= csr_bus.data;
      end
   end

   // Saturate the limit to the counter range
   assign limit_ext = 9'(limit_ff);
   assign limit_sat = (limit_ext > COUNT_MAX) ? COUNT_MAX[COUNT_WIDTH-1:0]
                                              : limit_ext[COUNT_WIDTH-1:0];

   // Accept a beat whenever the output register frees up
   assign req_ready     = ~rsp_valid_ff | rsp_bus.ready;
   assign req_bus.ready = req_ready;
   assign step          = req_bus.valid & req_ready;

   // Per-button lanes
   for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_lane
      bdmn_lane #(
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .step     (step),
         .pin      (req_bus.raw_pins[g]),
         .limit    (limit_sat),
         .level_nx (level_nx[g])
      );
      assign states[2*g +: 2] = level_nx[g];
   end

   // Merge lane levels into navigation state
   bdmn_nav #(
      .PAGE_COUNT (PAGE_COUNT)
   ) u_nav (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .level_nx (level_nx),
      .status   (status)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         states_ff <= states;
         status_ff <= status;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.button_states = states_ff;
   assign rsp_bus.in_menu       = status_ff.in_menu;
   assign rsp_bus.menu_page     = status_ff.menu_page;
   assign rsp_bus.redraw        = status_ff.redraw;

   // Checks
   logic bad_level;
   always_comb begin
      bad_level = 1'b0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
         if (states_ff[2*i +: 2] == 2'd3) begin
            bad_level = 1'b1;
         end
      end
   end

   a_accept_gives_beat: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("accepted beat produced no response");

   a_page_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (status_ff.menu_page <= PAGE_W'(PAGE_COUNT - 1)))
      else $error("menu page out of range");

   a_monitor_page_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff.in_menu == MODE_MONITOR) |-> (status_ff.menu_page == '0))
      else $error("monitor screen with nonzero page");

   a_level_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !bad_level)
      else $error("invalid button level code");

endmodule
`default_nettype wire
